@@ hw/rtl/sit_pkg.sv @@
// shared widths and payload types for the segment intersection test
// no dependencies; used by every module under hw/rtl

package sit_pkg;

   localparam int COORD_W = 16;                  // signed Q12.4 coordinate
   localparam int TOL_W   = 8;                   // tolerance register
   localparam int DIFF_W  = COORD_W + 1;         // endpoint differences
   localparam int DPROD_W = 2 * DIFF_W;          // difference products
   localparam int DET_W   = DPROD_W + 1;         // determinant
   localparam int CPROD_W = 2 * COORD_W;         // coordinate products
   localparam int CROSS_W = CPROD_W + 1;         // pre / post cross terms
   localparam int NPROD_W = CROSS_W + DIFF_W;    // numerator products
   localparam int NUM_W   = NPROD_W + 1;         // numerators
   localparam int BND_W   = COORD_W + 2;         // widened range bounds
   localparam int SCL_W   = BND_W + DET_W;       // bound times |d|

   typedef struct packed {
      logic signed [COORD_W-1:0] a_start_x;
      logic signed [COORD_W-1:0] a_start_y;
      logic signed [COORD_W-1:0] a_end_x;
      logic signed [COORD_W-1:0] a_end_y;
      logic signed [COORD_W-1:0] b_start_x;
      logic signed [COORD_W-1:0] b_start_y;
      logic signed [COORD_W-1:0] b_end_x;
      logic signed [COORD_W-1:0] b_end_y;
   } sit_req_type;

   typedef struct packed {
      logic hit;
      logic parallel;
   } sit_rsp_type;

   // widened ranges on each axis for both segments
   typedef struct packed {
      logic signed [BND_W-1:0] ax_lo;
      logic signed [BND_W-1:0] ax_hi;
      logic signed [BND_W-1:0] bx_lo;
      logic signed [BND_W-1:0] bx_hi;
      logic signed [BND_W-1:0] ay_lo;
      logic signed [BND_W-1:0] ay_hi;
      logic signed [BND_W-1:0] by_lo;
      logic signed [BND_W-1:0] by_hi;
   } sit_bnd_type;

   // front end result: determinant and cross terms
   typedef struct packed {
      logic                     valid;
      logic signed [DET_W-1:0]  d;
      logic signed [CROSS_W-1:0] pre;
      logic signed [CROSS_W-1:0] post;
      logic signed [DIFF_W-1:0] dxa;
      logic signed [DIFF_W-1:0] dya;
      logic signed [DIFF_W-1:0] dxb;
      logic signed [DIFF_W-1:0] dyb;
      sit_bnd_type              bnd;
   } sit_det_type;

   // normalised crossing point numerators over a non-negative denominator
   typedef struct packed {
      logic                    valid;
      logic                    parallel;
      logic signed [NUM_W-1:0] nx;
      logic signed [NUM_W-1:0] ny;
      logic signed [DET_W-1:0] dabs;
      sit_bnd_type             bnd;
   } sit_num_type;

endpackage

@@ hw/rtl/sit_front.sv @@
// stages 1 to 3: differences, bounds, products, determinant and cross terms
// depends on sit_pkg

module sit_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  sit_pkg::sit_req_type           req_data,
   input  logic [sit_pkg::TOL_W-1:0]      tol,
   output sit_pkg::sit_det_type           det
);

   typedef struct packed {
      logic signed [sit_pkg::COORD_W-1:0] x1;
      logic signed [sit_pkg::COORD_W-1:0] y1;
      logic signed [sit_pkg::COORD_W-1:0] x2;
      logic signed [sit_pkg::COORD_W-1:0] y2;
      logic signed [sit_pkg::COORD_W-1:0] x3;
      logic signed [sit_pkg::COORD_W-1:0] y3;
      logic signed [sit_pkg::COORD_W-1:0] x4;
      logic signed [sit_pkg::COORD_W-1:0] y4;
      logic signed [sit_pkg::DIFF_W-1:0]  dxa;
      logic signed [sit_pkg::DIFF_W-1:0]  dya;
      logic signed [sit_pkg::DIFF_W-1:0]  dxb;
      logic signed [sit_pkg::DIFF_W-1:0]  dyb;
      logic [sit_pkg::TOL_W-1:0]          tol;
   } s1_type;

   typedef struct packed {
      logic signed [sit_pkg::DPROD_W-1:0] p_dxa_dyb;
      logic signed [sit_pkg::DPROD_W-1:0] p_dya_dxb;
      logic signed [sit_pkg::CPROD_W-1:0] p_x1y2;
      logic signed [sit_pkg::CPROD_W-1:0] p_y1x2;
      logic signed [sit_pkg::CPROD_W-1:0] p_x3y4;
      logic signed [sit_pkg::CPROD_W-1:0] p_y3x4;
      logic signed [sit_pkg::DIFF_W-1:0]  dxa;
      logic signed [sit_pkg::DIFF_W-1:0]  dya;
      logic signed [sit_pkg::DIFF_W-1:0]  dxb;
      logic signed [sit_pkg::DIFF_W-1:0]  dyb;
      sit_pkg::sit_bnd_type               bnd;
   } s2_type;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   s1_type               s1_ff, s1_in;
   s2_type               s2_ff, s2_in;
   sit_pkg::sit_det_type s3_ff, s3_in;

   logic signed [sit_pkg::BND_W-1:0] tol_ext;

   function automatic logic signed [sit_pkg::BND_W-1:0] lo_bound(
      input logic signed [sit_pkg::COORD_W-1:0] c1,
      input logic signed [sit_pkg::COORD_W-1:0] c2,
      input logic signed [sit_pkg::BND_W-1:0]   t
   );
      logic signed [sit_pkg::COORD_W-1:0] m;
      m = (c2 < c1) ? c2 : c1;
      return sit_pkg::BND_W'(m) - t;
   endfunction

   function automatic logic signed [sit_pkg::BND_W-1:0] hi_bound(
      input logic signed [sit_pkg::COORD_W-1:0] c1,
      input logic signed [sit_pkg::COORD_W-1:0] c2,
      input logic signed [sit_pkg::BND_W-1:0]   t
   );
      logic signed [sit_pkg::COORD_W-1:0] m;
      m = (c1 < c2) ? c2 : c1;
      return sit_pkg::BND_W'(m) + t;
   endfunction

   // stage 1: endpoint differences
   always_comb begin
      s1_in.x1  = req_data.a_start_x;
      s1_in.y1  = req_data.a_start_y;
      s1_in.x2  = req_data.a_end_x;
      s1_in.y2  = req_data.a_end_y;
      s1_in.x3  = req_data.b_start_x;
      s1_in.y3  = req_data.b_start_y;
      s1_in.x4  = req_data.b_end_x;
      s1_in.y4  = req_data.b_end_y;
      s1_in.dxa = sit_pkg::DIFF_W'(req_data.a_start_x) - sit_pkg::DIFF_W'(req_data.a_end_x);
      s1_in.dya = sit_pkg::DIFF_W'(req_data.a_start_y) - sit_pkg::DIFF_W'(req_data.a_end_y);
      s1_in.dxb = sit_pkg::DIFF_W'(req_data.b_start_x) - sit_pkg::DIFF_W'(req_data.b_end_x);
      s1_in.dyb = sit_pkg::DIFF_W'(req_data.b_start_y) - sit_pkg::DIFF_W'(req_data.b_end_y);
      s1_in.tol = tol;
   end

   assign tol_ext = sit_pkg::BND_W'($signed({1'b0, s1_ff.tol}));

   // stage 2: one multiplier per product, bounds widened by the tolerance
   always_comb begin
      s2_in.p_dxa_dyb = sit_pkg::DPROD_W'(s1_ff.dxa) * sit_pkg::DPROD_W'(s1_ff.dyb);
      s2_in.p_dya_dxb = sit_pkg::DPROD_W'(s1_ff.dya) * sit_pkg::DPROD_W'(s1_ff.dxb);
      s2_in.p_x1y2    = sit_pkg::CPROD_W'(s1_ff.x1) * sit_pkg::CPROD_W'(s1_ff.y2);
      s2_in.p_y1x2    = sit_pkg::CPROD_W'(s1_ff.y1) * sit_pkg::CPROD_W'(s1_ff.x2);
      s2_in.p_x3y4    = sit_pkg::CPROD_W'(s1_ff.x3) * sit_pkg::CPROD_W'(s1_ff.y4);
      s2_in.p_y3x4    = sit_pkg::CPROD_W'(s1_ff.y3) * sit_pkg::CPROD_W'(s1_ff.x4);
      s2_in.dxa       = s1_ff.dxa;
      s2_in.dya       = s1_ff.dya;
      s2_in.dxb       = s1_ff.dxb;
      s2_in.dyb       = s1_ff.dyb;
      s2_in.bnd.ax_lo = lo_bound(s1_ff.x1, s1_ff.x2, tol_ext);
      s2_in.bnd.ax_hi = hi_bound(s1_ff.x1, s1_ff.x2, tol_ext);
      s2_in.bnd.bx_lo = lo_bound(s1_ff.x3, s1_ff.x4, tol_ext);
      s2_in.bnd.bx_hi = hi_bound(s1_ff.x3, s1_ff.x4, tol_ext);
      s2_in.bnd.ay_lo = lo_bound(s1_ff.y1, s1_ff.y2, tol_ext);
      s2_in.bnd.ay_hi = hi_bound(s1_ff.y1, s1_ff.y2, tol_ext);
      s2_in.bnd.by_lo = lo_bound(s1_ff.y3, s1_ff.y4, tol_ext);
      s2_in.bnd.by_hi = hi_bound(s1_ff.y3, s1_ff.y4, tol_ext);
   end

   // stage 3: determinant and cross terms
   always_comb begin
      s3_in.valid = s2_valid_ff;
      s3_in.d     = sit_pkg::DET_W'(s2_ff.p_dxa_dyb) - sit_pkg::DET_W'(s2_ff.p_dya_dxb);
      s3_in.pre   = sit_pkg::CROSS_W'(s2_ff.p_x1y2) - sit_pkg::CROSS_W'(s2_ff.p_y1x2);
      s3_in.post  = sit_pkg::CROSS_W'(s2_ff.p_x3y4) - sit_pkg::CROSS_W'(s2_ff.p_y3x4);
      s3_in.dxa   = s2_ff.dxa;
      s3_in.dya   = s2_ff.dya;
      s3_in.dxb   = s2_ff.dxb;
      s3_in.dyb   = s2_ff.dyb;
      s3_in.bnd   = s2_ff.bnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   always_comb begin
      det       = s3_ff;
      det.valid = s3_valid_ff;
   end

endmodule

@@ hw/rtl/sit_solve.sv @@
// stages 4 and 5: crossing point numerators, sign normalised against |d|
// depends on sit_pkg

module sit_solve (
   input  logic                 clock,
   input  logic                 reset,
   input  sit_pkg::sit_det_type det,
   output sit_pkg::sit_num_type num
);

   typedef struct packed {
      logic signed [sit_pkg::NPROD_W-1:0] p_pre_dxb;
      logic signed [sit_pkg::NPROD_W-1:0] p_dxa_post;
      logic signed [sit_pkg::NPROD_W-1:0] p_pre_dyb;
      logic signed [sit_pkg::NPROD_W-1:0] p_dya_post;
      logic signed [sit_pkg::DET_W-1:0]   d;
      sit_pkg::sit_bnd_type               bnd;
   } s4_type;

   logic                 s4_valid_ff, s5_valid_ff;
   s4_type               s4_ff, s4_in;
   sit_pkg::sit_num_type s5_ff, s5_in;
   logic                 d_neg;

   // stage 4: numerator products
   always_comb begin
      s4_in.p_pre_dxb  = sit_pkg::NPROD_W'(det.pre) * sit_pkg::NPROD_W'(det.dxb);
      s4_in.p_dxa_post = sit_pkg::NPROD_W'(det.dxa) * sit_pkg::NPROD_W'(det.post);
      s4_in.p_pre_dyb  = sit_pkg::NPROD_W'(det.pre) * sit_pkg::NPROD_W'(det.dyb);
      s4_in.p_dya_post = sit_pkg::NPROD_W'(det.dya) * sit_pkg::NPROD_W'(det.post);
      s4_in.d          = det.d;
      s4_in.bnd        = det.bnd;
   end

   assign d_neg = s4_ff.d[sit_pkg::DET_W-1];

   // stage 5: a negative d swaps the subtraction order instead of negating afterwards
   always_comb begin
      s5_in.valid    = s4_valid_ff;
      s5_in.parallel = (s4_ff.d == '0);
      if (d_neg) begin
         s5_in.nx   = sit_pkg::NUM_W'(s4_ff.p_dxa_post) - sit_pkg::NUM_W'(s4_ff.p_pre_dxb);
         s5_in.ny   = sit_pkg::NUM_W'(s4_ff.p_dya_post) - sit_pkg::NUM_W'(s4_ff.p_pre_dyb);
         s5_in.dabs = -s4_ff.d;
      end else begin
         s5_in.nx   = sit_pkg::NUM_W'(s4_ff.p_pre_dxb) - sit_pkg::NUM_W'(s4_ff.p_dxa_post);
         s5_in.ny   = sit_pkg::NUM_W'(s4_ff.p_pre_dyb) - sit_pkg::NUM_W'(s4_ff.p_dya_post);
         s5_in.dabs = s4_ff.d;
      end
      s5_in.bnd = s4_ff.bnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= det.valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_ff <= s4_in;
      s5_ff <= s5_in;
   end

   always_comb begin
      num       = s5_ff;
      num.valid = s5_valid_ff;
   end

endmodule

@@ hw/rtl/sit_check.sv @@
// stages 6 and 7: bounds scaled by |d| and compared with the numerators
// depends on sit_pkg

module sit_check (
   input  logic                 clock,
   input  logic                 reset,
   input  sit_pkg::sit_num_type num,
   output logic                 rsp_valid,
   output sit_pkg::sit_rsp_type rsp_data
);

   typedef struct packed {
      logic                             parallel;
      logic signed [sit_pkg::SCL_W-1:0] nx;
      logic signed [sit_pkg::SCL_W-1:0] ny;
      logic signed [sit_pkg::SCL_W-1:0] ax_lo;
      logic signed [sit_pkg::SCL_W-1:0] ax_hi;
      logic signed [sit_pkg::SCL_W-1:0] bx_lo;
      logic signed [sit_pkg::SCL_W-1:0] bx_hi;
      logic signed [sit_pkg::SCL_W-1:0] ay_lo;
      logic signed [sit_pkg::SCL_W-1:0] ay_hi;
      logic signed [sit_pkg::SCL_W-1:0] by_lo;
      logic signed [sit_pkg::SCL_W-1:0] by_hi;
   } s6_type;

   logic                 s6_valid_ff, s7_valid_ff;
   s6_type               s6_ff, s6_in;
   sit_pkg::sit_rsp_type s7_ff, s7_in;
   logic                 in_x, in_y;

   function automatic logic signed [sit_pkg::SCL_W-1:0] scale(
      input logic signed [sit_pkg::BND_W-1:0] b,
      input logic signed [sit_pkg::DET_W-1:0] d
   );
      return sit_pkg::SCL_W'(b) * sit_pkg::SCL_W'(d);
   endfunction

   // stage 6: eight bound multipliers side by side
   always_comb begin
      s6_in.parallel = num.parallel;
      s6_in.nx       = sit_pkg::SCL_W'(num.nx);
      s6_in.ny       = sit_pkg::SCL_W'(num.ny);
      s6_in.ax_lo    = scale(num.bnd.ax_lo, num.dabs);
      s6_in.ax_hi    = scale(num.bnd.ax_hi, num.dabs);
      s6_in.bx_lo    = scale(num.bnd.bx_lo, num.dabs);
      s6_in.bx_hi    = scale(num.bnd.bx_hi, num.dabs);
      s6_in.ay_lo    = scale(num.bnd.ay_lo, num.dabs);
      s6_in.ay_hi    = scale(num.bnd.ay_hi, num.dabs);
      s6_in.by_lo    = scale(num.bnd.by_lo, num.dabs);
      s6_in.by_hi    = scale(num.bnd.by_hi, num.dabs);
   end

   // stage 7: boundaries count as inside
   assign in_x = (s6_ff.nx >= s6_ff.ax_lo) && (s6_ff.nx <= s6_ff.ax_hi) &&
                 (s6_ff.nx >= s6_ff.bx_lo) && (s6_ff.nx <= s6_ff.bx_hi);
   assign in_y = (s6_ff.ny >= s6_ff.ay_lo) && (s6_ff.ny <= s6_ff.ay_hi) &&
                 (s6_ff.ny >= s6_ff.by_lo) && (s6_ff.ny <= s6_ff.by_hi);

   always_comb begin
      s7_in.parallel = s6_ff.parallel;
      s7_in.hit      = !s6_ff.parallel && in_x && in_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= num.valid;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_ff <= s6_in;
      s7_ff <= s7_in;
   end

   assign rsp_valid = s7_valid_ff;
   assign rsp_data  = s7_ff;

endmodule

@@ hw/rtl/segment_intersection_test_top.sv @@
// top level of the segment intersection test: tolerance register and pipeline
// depends on sit_pkg, sit_front, sit_solve, sit_check

// Takes one segment pair per clock cycle while busy is low and returns one
// result per pair, in order, after the seven register stages of the pipeline
// (differences, products, determinant, numerator products, sign normalisation,
// bound scaling, compare). The result is shown on rsp_data for exactly one
// cycle with rsp_valid high; there is no backpressure, so the receiver must
// take it then. busy is high only while reset is asserted. The tolerance
// register is written through the csr port, which is always ready; write it
// only while no pair is in flight. Coordinates are signed Q12.4, tolerance
// is in coordinate LSBs, and a crossing exactly on a widened range edge
// counts as a hit. A zero determinant (parallel, collinear or degenerate
// segments) reports parallel and never a hit.

module segment_intersection_test_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  sit_pkg::sit_req_type           req_data,
   output logic                           rsp_valid,
   output sit_pkg::sit_rsp_type           rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sit_pkg::TOL_W-1:0]      csr_wdata
);

   logic [sit_pkg::TOL_W-1:0] tol_ff, tol_in;
   logic                      req_accept;
   sit_pkg::sit_det_type      det;
   sit_pkg::sit_num_type      num;

   assign busy       = reset;
   assign csr_ready  = 1'b1;
   assign req_accept = start && !busy;

   assign tol_in = (csr_valid && csr_ready) ? csr_wdata : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else begin
         tol_ff <= tol_in;
      end
   end

   sit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_accept),
      .req_data  (req_data),
      .tol       (tol_ff),
      .det       (det)
   );

   sit_solve u_solve (
      .clock (clock),
      .reset (reset),
      .det   (det),
      .num   (num)
   );

   sit_check u_check (
      .clock     (clock),
      .reset     (reset),
      .num       (num),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // every result comes from an accepted transfer, and every accepted transfer gives a result
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, 7))
      else $error("result without a matching transfer");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##7 rsp_valid)
      else $error("transfer lost in the pipeline");

   a_parallel_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parallel |-> !rsp_data.hit)
      else $error("hit reported on a zero determinant");

   // segment a with coincident endpoints must come out parallel
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.a_start_x == req_data.a_end_x &&
                         req_data.a_start_y == req_data.a_end_y, 7)
      |-> rsp_data.parallel)
      else $error("degenerate segment not reported as parallel");

endmodule
